### hw/rtl/lkfi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkfi_pkg
// Shared types and constants of the looping keyframe interpolator.
// ----------------------------------------------------------------------------
package lkfi_pkg;

	// register indexes of the configuration port
	localparam int unsigned CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIME_SCALE   = 2'd0,
		REG_CYCLE_LENGTH = 2'd1,
		REG_FRAME_COUNT  = 2'd2
	} cfg_reg_t;

	// item opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	// 1.0 in Q16.16
	localparam logic [30:0] ONE_Q16 = 31'h0001_0000;

	// shared divider geometry
	localparam int unsigned DIV_N_W = 64;
	localparam int unsigned DIV_D_W = 40;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_N_W-1:0] quotient;
		logic [DIV_D_W-1:0] remainder;
	} div_rsp_t;

	// one keyframe table entry
	typedef struct packed {
		logic [31:0] ktime;
		logic [31:0] kvalue;
	} key_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LAST_RD,
		S_FIRST_RD,
		S_CHECK,
		S_MOD_START,
		S_MOD_WAIT,
		S_SMP_MUL,
		S_SMP_START,
		S_SMP_WAIT,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_FAC,
		S_FAC_WAIT,
		S_MUL,
		S_ADD,
		S_DONE
	} state_t;

endpackage

### hw/rtl/lkfi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkfi channel interfaces
// Item, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lkfi_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [3:0]  frame_index;
	logic [31:0] frame_time;
	logic signed [31:0] frame_value;
	logic signed [31:0] elapsed_time;

	modport source (output valid, op, frame_index, frame_time, frame_value, elapsed_time,
		input ready);
	modport sink (input valid, op, frame_index, frame_time, frame_value, elapsed_time,
		output ready);
endinterface

interface lkfi_out_if;
	logic        valid;
	logic        ready;
	logic [30:0] value;

	modport source (output valid, value, input ready);
	modport sink (input valid, value, output ready);
endinterface

interface lkfi_cfg_if;
	logic        valid;
	logic        ready;
	logic [lkfi_pkg::CFG_IDX_W-1:0] index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/lkfi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkfi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lkfi_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/lkfi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkfi_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lkfi_div (
	input  logic               clk,
	input  logic               arst_n,
	input  lkfi_pkg::div_req_t req,
	output lkfi_pkg::div_rsp_t rsp
);

	localparam int unsigned NW    = lkfi_pkg::DIV_N_W;
	localparam int unsigned DW    = lkfi_pkg::DIV_D_W;
	localparam int unsigned CNT_W = $clog2(NW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    div_q;
	logic [DW:0]      trial;
	logic [DW:0]      diff;
	logic             ge;

	// one trial subtraction
	always_comb begin
		trial = {rem_q, quo_q[NW-1]};
		diff  = trial - {1'b0, div_q};
		ge    = trial >= {1'b0, div_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

### hw/rtl/looping_keyframe_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// looping_keyframe_interpolator_top
// Keyframe table with looped, time-scaled piecewise-linear evaluation.
// ----------------------------------------------------------------------------
// A write word stores one keyframe in the table and gives no result. An
// evaluate word gives one value: the last and first frames are fetched, the
// shared divider makes one pass for the loop wrap and a second for the
// mapping onto the keyframe span, the keyframes are scanned over the single
// table read port, and a third divider pass gives the blend factor. Special
// cases (no frames, one frame, zero last frame time, zero time scale, sample
// before the first frame, degenerate segment) finish early.
// One word is worked on at a time; a finished result waits in the output
// register while the next word is taken. Configuration writes are accepted at
// any time but must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module looping_keyframe_interpolator_top #(
	parameter int unsigned MAX_FRAMES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	lkfi_in_if.sink     item_in,
	lkfi_out_if.source  result_out,
	lkfi_cfg_if.sink    cfg
);

	localparam int unsigned AW    = $clog2(MAX_FRAMES);
	localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);

	lkfi_pkg::state_t   state_q, state_d;
	lkfi_pkg::div_req_t div_req;
	lkfi_pkg::div_rsp_t div_rsp;
	lkfi_pkg::key_t     wkey, rkey;

	logic [15:0] time_scale_q;
	logic [31:0] cycle_length_q;
	logic [4:0]  frame_count_q;

	logic signed [31:0] elapsed_q;
	logic [31:0] src_q, vlast_q, t0_q, v0_q, tp_q, vp_q, vc_q;
	logic [31:0] ct_q, sample_q, dur_q;
	logic signed [48:0] prod_q;
	logic [63:0] smp_prod_q;
	logic [16:0] fac_q;
	logic signed [50:0] mprod_q;
	logic [AW-1:0] idx_q;
	logic [30:0] res_q, res_d;
	logic        fin;
	logic        out_valid_q;
	logic [30:0] out_value_q;

	logic          acc;
	logic          we;
	logic [AW-1:0] raddr;
	logic [CNT_W-1:0] n;
	logic [AW-1:0] n_m1;
	logic [31:0]   cyc;
	logic [39:0]   modv;
	logic [39:0]   rem_adj;
	logic [48:0]   prod_mag;
	logic [31:0]   span;
	logic signed [35:0] sum;
	logic          out_free;

	function automatic logic [30:0] clip32(input logic [31:0] v);
		return v[31] ? 31'd0 : v[30:0];
	endfunction

	// frames in use, loop cycle and handshakes
	always_comb begin
		if (32'(frame_count_q) > MAX_FRAMES) begin
			n = CNT_W'(MAX_FRAMES);
		end else begin
			n = CNT_W'(frame_count_q);
		end
		n_m1     = AW'(n - 1'b1);
		cyc      = (cycle_length_q != '0) ? cycle_length_q : src_q;
		modv     = {cyc, 8'd0};
		prod_mag = prod_q[48] ? (~prod_q + 49'd1) : prod_q;
		span     = sample_q - tp_q;
		rem_adj  = (prod_q[48] && div_rsp.remainder != '0) ?
			modv - div_rsp.remainder : div_rsp.remainder;
		sum      = $signed({{4{vp_q[31]}}, vp_q}) + 36'(mprod_q >>> 16);
		acc      = item_in.valid && item_in.ready;
		out_free = !out_valid_q || result_out.ready;
	end

	assign item_in.ready = (state_q == lkfi_pkg::S_IDLE);
	assign cfg.ready     = 1'b1;

	// keyframe table
	assign we          = acc && item_in.op == lkfi_pkg::OP_WRITE
		&& 32'(item_in.frame_index) < MAX_FRAMES;
	assign wkey.ktime  = item_in.frame_time;
	assign wkey.kvalue = item_in.frame_value;

	lkfi_ram #(
		.WIDTH($bits(lkfi_pkg::key_t)),
		.DEPTH(MAX_FRAMES)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(AW'(item_in.frame_index)),
		.wdata(wkey),
		.raddr(raddr),
		.rdata(rkey)
	);

	lkfi_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_scale_q   <= 16'd256;
			cycle_length_q <= '0;
			frame_count_q  <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				lkfi_pkg::REG_TIME_SCALE:   time_scale_q   <= cfg.data[15:0];
				lkfi_pkg::REG_CYCLE_LENGTH: cycle_length_q <= cfg.data;
				lkfi_pkg::REG_FRAME_COUNT:  frame_count_q  <= cfg.data[4:0];
				default: ;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkfi_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, table read address, divider requests
	always_comb begin
		state_d          = state_q;
		raddr            = '0;
		div_req.start    = 1'b0;
		div_req.dividend = smp_prod_q;
		div_req.divisor  = {8'd0, cyc};
		fin              = 1'b0;
		res_d            = '0;
		unique case (state_q)
			lkfi_pkg::S_IDLE: begin
				if (acc && item_in.op == lkfi_pkg::OP_EVAL) begin
					if (n == '0) begin
						fin     = 1'b1;
						res_d   = lkfi_pkg::ONE_Q16;
						state_d = lkfi_pkg::S_DONE;
					end else begin
						state_d = lkfi_pkg::S_LAST_RD;
					end
				end
			end
			lkfi_pkg::S_LAST_RD: begin
				raddr   = n_m1;
				state_d = lkfi_pkg::S_FIRST_RD;
			end
			lkfi_pkg::S_FIRST_RD: begin
				raddr = '0;
				if (n == CNT_W'(1)) begin
					fin     = 1'b1;
					res_d   = clip32(rkey.kvalue);
					state_d = lkfi_pkg::S_DONE;
				end else begin
					state_d = lkfi_pkg::S_CHECK;
				end
			end
			lkfi_pkg::S_CHECK: begin
				if (src_q == '0) begin
					fin     = 1'b1;
					res_d   = clip32(vlast_q);
					state_d = lkfi_pkg::S_DONE;
				end else if (time_scale_q == '0) begin
					fin     = 1'b1;
					res_d   = clip32(rkey.kvalue);
					state_d = lkfi_pkg::S_DONE;
				end else begin
					state_d = lkfi_pkg::S_MOD_START;
				end
			end
			lkfi_pkg::S_MOD_START: begin
				div_req.start    = 1'b1;
				div_req.dividend = {16'd0, prod_mag[47:0]};
				div_req.divisor  = modv;
				state_d          = lkfi_pkg::S_MOD_WAIT;
			end
			lkfi_pkg::S_MOD_WAIT: begin
				if (div_rsp.done) begin
					state_d = lkfi_pkg::S_SMP_MUL;
				end
			end
			lkfi_pkg::S_SMP_MUL: begin
				state_d = lkfi_pkg::S_SMP_START;
			end
			lkfi_pkg::S_SMP_START: begin
				div_req.start = 1'b1;
				state_d       = lkfi_pkg::S_SMP_WAIT;
			end
			lkfi_pkg::S_SMP_WAIT: begin
				if (div_rsp.done) begin
					if (div_rsp.quotient[31:0] <= t0_q) begin
						fin     = 1'b1;
						res_d   = clip32(v0_q);
						state_d = lkfi_pkg::S_DONE;
					end else begin
						state_d = lkfi_pkg::S_SCAN_RD;
					end
				end
			end
			lkfi_pkg::S_SCAN_RD: begin
				raddr   = idx_q;
				state_d = lkfi_pkg::S_SCAN_CHK;
			end
			lkfi_pkg::S_SCAN_CHK: begin
				if (sample_q > rkey.ktime) begin
					if (idx_q == n_m1) begin
						fin     = 1'b1;
						res_d   = clip32(vlast_q);
						state_d = lkfi_pkg::S_DONE;
					end else begin
						state_d = lkfi_pkg::S_SCAN_RD;
					end
				end else if (rkey.ktime <= tp_q) begin
					fin     = 1'b1;
					res_d   = clip32(rkey.kvalue);
					state_d = lkfi_pkg::S_DONE;
				end else begin
					state_d = lkfi_pkg::S_FAC;
				end
			end
			lkfi_pkg::S_FAC: begin
				if (sample_q <= tp_q || span >= dur_q) begin
					state_d = lkfi_pkg::S_MUL;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = {16'd0, span, 16'd0};
					div_req.divisor  = {8'd0, dur_q};
					state_d          = lkfi_pkg::S_FAC_WAIT;
				end
			end
			lkfi_pkg::S_FAC_WAIT: begin
				if (div_rsp.done) begin
					state_d = lkfi_pkg::S_MUL;
				end
			end
			lkfi_pkg::S_MUL: begin
				state_d = lkfi_pkg::S_ADD;
			end
			lkfi_pkg::S_ADD: begin
				fin     = 1'b1;
				res_d   = sum[35] ? 31'd0 : sum[30:0];
				state_d = lkfi_pkg::S_DONE;
			end
			lkfi_pkg::S_DONE: begin
				if (out_free) begin
					state_d = lkfi_pkg::S_IDLE;
				end
			end
			default: state_d = lkfi_pkg::S_IDLE;
		endcase
	end

	// evaluation datapath
	always_ff @(posedge clk) begin
		if (fin) begin
			res_q <= res_d;
		end
		case (state_q)
			lkfi_pkg::S_IDLE: begin
				if (acc) begin
					elapsed_q <= item_in.elapsed_time;
				end
			end
			lkfi_pkg::S_FIRST_RD: begin
				src_q   <= rkey.ktime;
				vlast_q <= rkey.kvalue;
			end
			lkfi_pkg::S_CHECK: begin
				t0_q   <= rkey.ktime;
				v0_q   <= rkey.kvalue;
				tp_q   <= rkey.ktime;
				vp_q   <= rkey.kvalue;
				prod_q <= elapsed_q * $signed({1'b0, time_scale_q});
			end
			lkfi_pkg::S_MOD_WAIT: begin
				if (div_rsp.done) begin
					ct_q <= rem_adj[39:8];
				end
			end
			lkfi_pkg::S_SMP_MUL: begin
				smp_prod_q <= 64'(ct_q) * 64'(src_q);
			end
			lkfi_pkg::S_SMP_WAIT: begin
				sample_q <= div_rsp.quotient[31:0];
				idx_q    <= AW'(1);
			end
			lkfi_pkg::S_SCAN_CHK: begin
				if (sample_q > rkey.ktime) begin
					tp_q  <= rkey.ktime;
					vp_q  <= rkey.kvalue;
					idx_q <= idx_q + 1'b1;
				end else begin
					vc_q  <= rkey.kvalue;
					dur_q <= rkey.ktime - tp_q;
				end
			end
			lkfi_pkg::S_FAC: begin
				if (sample_q <= tp_q) begin
					fac_q <= '0;
				end else if (span >= dur_q) begin
					fac_q <= 17'h1_0000;
				end
			end
			lkfi_pkg::S_FAC_WAIT: begin
				if (div_rsp.done) begin
					fac_q <= div_rsp.quotient[16:0];
				end
			end
			lkfi_pkg::S_MUL: begin
				mprod_q <= ($signed({vc_q[31], vc_q}) - $signed({vp_q[31], vp_q}))
					* $signed({1'b0, fac_q});
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == lkfi_pkg::S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lkfi_pkg::S_DONE && out_free) begin
			out_value_q <= res_q;
		end
	end

	assign result_out.valid = out_valid_q;
	assign result_out.value = out_value_q;

	// a write word never produces a result
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && item_in.op == lkfi_pkg::OP_WRITE) |=> !$rose(result_out.valid))
		else $error("result raised after a write word");

	// divider completes only while the sequencer waits for it
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == lkfi_pkg::S_MOD_WAIT
			|| state_q == lkfi_pkg::S_SMP_WAIT || state_q == lkfi_pkg::S_FAC_WAIT))
		else $error("divider done outside a wait state");

	// empty table evaluates to one
	a_empty_one: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && item_in.op == lkfi_pkg::OP_EVAL && n == '0)
		|=> (state_q == lkfi_pkg::S_DONE && res_q == lkfi_pkg::ONE_Q16))
		else $error("empty table did not give one");

endmodule

### dv/looping_keyframe_interpolator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// looping_keyframe_interpolator_top_tb
// Checks the looping keyframe interpolator against a cycle-free predictor.
// Keyframe tables are loaded with write words, evaluate words are checked
// value by value in order, registers are changed between phases while the
// block is idle, and both channels stall in random bursts.
// ----------------------------------------------------------------------------
module looping_keyframe_interpolator_top_tb;

	localparam int unsigned NUM_FRAMES = 16;
	localparam logic [lkfi_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int unsigned ITEM_TARGET = 950;
	localparam int unsigned QUIET_AFTER = 820;
	localparam int unsigned SETTLE_CYCLES = 400;
	localparam int unsigned HOLD_CYCLES = 700;

	// interpolation predictor and queue of pending values
	class interp_scoreboard;
		logic [15:0] tscale;
		logic [31:0] cyc_len;
		logic [4:0] fcount;
		logic [31:0] ktime [NUM_FRAMES];
		logic signed [31:0] kval [NUM_FRAMES];
		logic [30:0] pending_values [$];
		int unsigned mismatches;
		int unsigned strays;
		int unsigned checked;

		function void clear();
			tscale = 16'd256;
			cyc_len = '0;
			fcount = '0;
			mismatches = 0;
			strays = 0;
			checked = 0;
			pending_values.delete();
		endfunction

		function void set_reg(logic [lkfi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
			case (idx)
				lkfi_pkg::REG_TIME_SCALE: begin
					tscale = data[15:0];
				end
				lkfi_pkg::REG_CYCLE_LENGTH: begin
					cyc_len = data;
				end
				lkfi_pkg::REG_FRAME_COUNT: begin
					fcount = data[4:0];
				end
				default: begin
				end
			endcase
		endfunction

		function logic [30:0] floor0(longint v);
			return (v < 0) ? 31'd0 : v[30:0];
		endfunction

		function logic [30:0] interpolate(logic signed [31:0] el);
			int unsigned n;
			longint unsigned src, cyc, ct, smp, tp, tc, dur, fac;
			longint prod, md, rem, delta;
			n = (fcount > NUM_FRAMES) ? NUM_FRAMES : fcount;
			if (n == 0)
				return lkfi_pkg::ONE_Q16;
			if (n == 1)
				return floor0(kval[0]);
			src = ktime[n-1];
			if (src == 0)
				return floor0(kval[n-1]);
			if (tscale == 0)
				return floor0(kval[0]);
			cyc = (cyc_len != 0) ? longint'(cyc_len) : src;
			// wrap the scaled time into the loop, then map onto the frame span
			prod = longint'(el) * longint'({16'd0, tscale});
			md = longint'(cyc) <<< 8;
			rem = prod % md;
			if (rem < 0)
				rem += md;
			ct = longint'(rem) >> 8;
			smp = (ct * src) / cyc;
			if (smp <= ktime[0])
				return floor0(kval[0]);
			// first frame at or after the sample closes the segment
			for (int unsigned i = 1; i < n; i++) begin
				tp = ktime[i-1];
				tc = ktime[i];
				if (smp > tc)
					continue;
				if (tc <= tp)
					return floor0(kval[i]);
				dur = tc - tp;
				if (smp <= tp)
					fac = 0;
				else if (smp - tp >= dur)
					fac = 65536;
				else
					fac = ((smp - tp) << 16) / dur;
				delta = longint'(kval[i]) - longint'(kval[i-1]);
				return floor0(longint'(kval[i-1]) + ((delta * longint'(fac)) >>> 16));
			end
			return floor0(kval[n-1]);
		endfunction

		function void note_word(logic op, logic [3:0] idx, logic [31:0] t,
				logic signed [31:0] v, logic signed [31:0] el);
			if (op == lkfi_pkg::OP_WRITE) begin
				ktime[idx] = t;
				kval[idx] = v;
			end else begin
				pending_values.push_back(interpolate(el));
			end
		endfunction

		function void check_value(logic [30:0] actual);
			logic [30:0] want;
			if (pending_values.size() == 0) begin
				strays++;
				if (strays + mismatches <= 10)
					$display("unexpected value %h", actual);
				return;
			end
			want = pending_values.pop_front();
			checked++;
			if (want !== actual) begin
				mismatches++;
				if (mismatches + strays <= 10)
					$display("value mismatch #%0d: expected %h, got %h",
						checked, want, actual);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	lkfi_in_if item_in ();
	lkfi_out_if result_out ();
	lkfi_cfg_if cfg ();

	interp_scoreboard sb;
	int unsigned words_sent;
	int unsigned values_seen;
	bit quiet;

	looping_keyframe_interpolator_top #(.MAX_FRAMES(NUM_FRAMES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_in(item_in),
		.result_out(result_out),
		.cfg(cfg)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#10ms;
		$display("Simulation FAILED");
		$finish;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_out.valid && result_out.ready) begin
			sb.check_value(result_out.value);
			values_seen++;
		end
	end

	// result side stalls, with one long hold-off while words keep coming
	initial begin
		bit held;
		held = 0;
		result_out.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && values_seen >= 150) begin
				held = 1;
				result_out.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				result_out.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			result_out.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	// one word on the item channel, then an optional gap
	task automatic send_word(logic op, logic [3:0] idx, logic [31:0] t,
			logic signed [31:0] v, logic signed [31:0] el);
		item_in.valid <= 1'b1;
		item_in.op <= op;
		item_in.frame_index <= idx;
		item_in.frame_time <= t;
		item_in.frame_value <= v;
		item_in.elapsed_time <= el;
		do @(posedge clk); while (!item_in.ready);
		sb.note_word(op, idx, t, v, el);
		words_sent++;
		if (words_sent >= QUIET_AFTER)
			quiet = 1;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_in.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic eval_at(logic signed [31:0] el);
		send_word(lkfi_pkg::OP_EVAL, 4'($urandom), $urandom, $urandom, el);
	endtask

	// wait out every pending value and any trailing write before a register write
	task automatic drain();
		item_in.valid <= 1'b0;
		while (sb.pending_values.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [lkfi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		sb.set_reg(idx, data);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// load a table whose times mostly rise, with repeats and disorder now and then
	task automatic load_table();
		logic [31:0] t;
		int unsigned shape;
		int unsigned span;
		shape = $urandom_range(0, 9);
		span = $urandom_range(0, 2) == 0 ? 32'h0100_0000 : 32'h0008_0000;
		t = $urandom_range(0, 32'h0004_0000);
		for (int unsigned s = 0; s < NUM_FRAMES; s++) begin
			if (shape == 0)
				t = 0;
			else if (shape == 1)
				t = $urandom;
			else if ($urandom_range(0, 7) != 0)
				t = t + $urandom_range(1, span);
			send_word(lkfi_pkg::OP_WRITE, 4'(s), t,
				$urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0008_0000) - 32'h0002_0000,
				$urandom);
		end
	endtask

	function automatic logic signed [31:0] pick_elapsed();
		case ($urandom_range(0, 3))
			0: pick_elapsed = $urandom;
			1: pick_elapsed = $urandom_range(0, 32'h0040_0000) - 32'h0010_0000;
			default: pick_elapsed = $urandom_range(0, 32'h0400_0000);
		endcase
	endfunction

	// stimulus
	initial begin
		int unsigned lim;
		sb = new();
		sb.clear();
		words_sent = 0;
		values_seen = 0;
		quiet = 0;
		arst_n = 1'b0;
		item_in.valid <= 1'b0;
		item_in.op <= lkfi_pkg::OP_WRITE;
		item_in.frame_index <= '0;
		item_in.frame_time <= '0;
		item_in.frame_value <= '0;
		item_in.elapsed_time <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= lkfi_pkg::REG_TIME_SCALE;
		cfg.data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes of values, single frame, scale extremes
		eval_at(32'sd0);
		for (int unsigned s = 0; s < NUM_FRAMES; s++)
			send_word(lkfi_pkg::OP_WRITE, 4'(s), 32'(s) << 17,
				(s == 3) ? 32'h7FFF_FFFF : (s == 4) ? 32'h8000_0000 :
				(s == 15) ? 32'hFFFF_FFFF : 32'(s) << 16, '0);
		drain();
		write_reg(lkfi_pkg::REG_FRAME_COUNT, 32'd1);
		eval_at(32'sh7FFF_FFFF);
		drain();
		write_reg(lkfi_pkg::REG_FRAME_COUNT, 32'd16);
		eval_at(32'sh7FFF_FFFF);
		eval_at(32'sh8000_0000);
		eval_at(-32'sh0003_8000);
		eval_at(32'sh0007_4000);
		drain();
		write_reg(lkfi_pkg::REG_TIME_SCALE, 32'd0);
		eval_at(32'sh0005_0000);
		drain();
		write_reg(lkfi_pkg::REG_TIME_SCALE, 32'h0000_FFFF);
		write_reg(lkfi_pkg::REG_CYCLE_LENGTH, 32'hFFFF_FFFF);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		eval_at(32'sh7FFF_FFFF);
		eval_at(32'sh0001_0000);
		drain();
		write_reg(lkfi_pkg::REG_FRAME_COUNT, 32'd31);
		write_reg(lkfi_pkg::REG_CYCLE_LENGTH, 32'd0);
		write_reg(lkfi_pkg::REG_TIME_SCALE, 32'd256);
		eval_at(32'sh0009_0000);
		eval_at(32'sh0040_0000);

		// random phases: new settings, often a new table, then evaluations
		while (words_sent < ITEM_TARGET) begin
			drain();
			case ($urandom_range(0, 4))
				0: write_reg(lkfi_pkg::REG_TIME_SCALE, 32'd256);
				1: write_reg(lkfi_pkg::REG_TIME_SCALE, 32'd0);
				2: write_reg(lkfi_pkg::REG_TIME_SCALE, 32'h0000_FFFF);
				default: write_reg(lkfi_pkg::REG_TIME_SCALE, $urandom_range(1, 32'h0000_0800));
			endcase
			case ($urandom_range(0, 5))
				0, 1: write_reg(lkfi_pkg::REG_CYCLE_LENGTH, 32'd0);
				2: write_reg(lkfi_pkg::REG_CYCLE_LENGTH, 32'hFFFF_FFFF);
				3: write_reg(lkfi_pkg::REG_CYCLE_LENGTH, $urandom);
				default: write_reg(lkfi_pkg::REG_CYCLE_LENGTH, $urandom_range(1, 32'h0100_0000));
			endcase
			write_reg(lkfi_pkg::REG_FRAME_COUNT, $urandom_range(0, 5) == 0 ?
				$urandom_range(0, 31) : $urandom_range(2, 16));
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_UNUSED, $urandom);
			if ($urandom_range(0, 2) != 0)
				load_table();
			lim = $urandom_range(8, 30);
			for (int unsigned k = 0; k < lim; k++) begin
				if ($urandom_range(0, 9) == 0)
					send_word(lkfi_pkg::OP_WRITE, 4'($urandom), $urandom, $urandom, $urandom);
				else
					eval_at(pick_elapsed());
			end
		end
		item_in.valid <= 1'b0;

		// let the last values come out
		lim = 0;
		while (sb.pending_values.size() != 0 && lim < 200000) begin
			@(posedge clk);
			lim++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending_values.size() == 0 && sb.mismatches == 0 && sb.strays == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/lkfi_pkg.sv
hw/rtl/lkfi_if.sv
hw/rtl/lkfi_ram.sv
hw/rtl/lkfi_div.sv
hw/rtl/looping_keyframe_interpolator_top.sv
dv/looping_keyframe_interpolator_top_tb.sv
